[design/periodic_distance_with_min_max_unit_defines.svh]
// ----------------------------------------------------------------------------
// periodic distance unit assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PERIODIC_DISTANCE_WITH_MIN_MAX_UNIT_DEFINES_SVH
`define PERIODIC_DISTANCE_WITH_MIN_MAX_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PDMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PDMM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PDMM_ASSERT(lbl, prop, msg)
`define PDMM_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[design/pdmm_pkg.sv]
// ----------------------------------------------------------------------------
// pdmm_pkg
// widths and shared types of the periodic distance unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdmm_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int DIST_W  = COORD_W + 2;
  localparam int SCNT_W  = $clog2(ROOT_W + 1);
  localparam int NLANES  = 3;
  localparam int LANE_LAT = 4;
  localparam int LCNT_W  = $clog2(LANE_LAT);

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

[design/pdmm_lane.sv]
// ----------------------------------------------------------------------------
// pdmm_lane
// one coordinate lane: difference, optional periodic wrap, magnitude, square
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdmm_lane import pdmm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      wrap_i,
  input  logic signed [COORD_W-1:0] a_i,
  input  logic signed [COORD_W-1:0] b_i,
  output logic        [SQ_W-1:0]    sq_o
);

  logic [DIFF_W-1:0]      diff_full;
  logic [DIFF_W-1:0]      diff_d;
  logic [DIFF_W-1:0]      diff_q;
  logic [MAG_W-1:0]       mag_q;
  logic [HI_W-1:0]        mag_hi;
  logic [LO_W-1:0]        mag_lo;
  logic [2*HI_W-1:0]      hh_q;
  logic [HI_W+LO_W-1:0]   hl_q;
  logic [2*LO_W-1:0]      ll_q;
  logic [SQ_W-1:0]        sq_d;
  logic [SQ_W-1:0]        sq_q;

  assign diff_full = {a_i[COORD_W-1], a_i} - {b_i[COORD_W-1], b_i};
  assign diff_d    = wrap_i ? {diff_full[COORD_W-1], diff_full[COORD_W-1:0]} : diff_full;
  assign mag_hi    = mag_q[MAG_W-1:LO_W];
  assign mag_lo    = mag_q[LO_W-1:0];
  assign sq_d      = (SQ_W'(hh_q) << (2 * LO_W)) + (SQ_W'(hl_q) << (LO_W + 1))
                   + SQ_W'(ll_q);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= diff_d;
    end
    mag_q <= diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
    hh_q  <= mag_hi * mag_hi;
    hl_q  <= mag_hi * mag_lo;
    ll_q  <= mag_lo * mag_lo;
    sq_q  <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

[design/pdmm_sqrt.sv]
// ----------------------------------------------------------------------------
// pdmm_sqrt
// iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdmm_sqrt import pdmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output sqrt_stat_t        stat_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign shifted = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == SCNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SCNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - SCNT_W'(1);
        if (cnt_q == SCNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? (shifted - trial) : shifted;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

[design/periodic_distance_with_min_max_unit.sv]
// ----------------------------------------------------------------------------
// periodic_distance_with_min_max_unit
// minimum-image distance between two 3d points with running min and max
//
//   port group   direction   handshake               payload
//   cfg          in          cfg_we_i                cfg_wdata_i (velocity mode)
//   in           in          in_valid_i / in_stall_o first_*_i, second_*_i
//   out          out         out_valid_o / out_stall_i distance_o, min/max_so_far_o
//
// an item runs from accept to the next accept through the lane and sum stages,
// the start state, the square-root iterations, the output load and back to idle
// reset: velocity mode 0, minimum all ones, maximum zero, no clearing pass
// the output register holds one result; a stalled output keeps the next
// finished root waiting and the input stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_distance_with_min_max_unit_defines.svh"

module periodic_distance_with_min_max_unit import pdmm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] first_x_i,
  input  logic signed [COORD_W-1:0] first_y_i,
  input  logic signed [COORD_W-1:0] first_z_i,
  input  logic signed [COORD_W-1:0] second_x_i,
  input  logic signed [COORD_W-1:0] second_y_i,
  input  logic signed [COORD_W-1:0] second_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic        [DIST_W-1:0]  distance_o,
  output logic        [DIST_W-1:0]  min_so_far_o,
  output logic        [DIST_W-1:0]  max_so_far_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LANE,
    S_START,
    S_ROOT,
    S_HOLD
  } state_e;

  state_e              state_q;
  logic [LCNT_W-1:0]   cnt_q;
  logic                vmode_q;
  logic                out_valid_q;
  logic [DIST_W-1:0]   dist_q;
  logic [DIST_W-1:0]   min_q;
  logic [DIST_W-1:0]   max_q;
  logic [DIST_W-1:0]   out_min_q;
  logic [DIST_W-1:0]   out_max_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SQ_W-1:0]     sq [NLANES];
  logic [COORD_W-1:0]  first_c  [NLANES];
  logic [COORD_W-1:0]  second_c [NLANES];
  logic                accept;
  logic                out_free;
  logic                root_ready;
  logic                load_out;
  logic [DIST_W-1:0]   root_dist;
  logic [DIST_W-1:0]   min_d;
  logic [DIST_W-1:0]   max_d;
  logic [ROOT_W-1:0]   root;
  sqrt_stat_t          sqrt_stat;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign first_c[0]  = first_x_i;
  assign first_c[1]  = first_y_i;
  assign first_c[2]  = first_z_i;
  assign second_c[0] = second_x_i;
  assign second_c[1] = second_y_i;
  assign second_c[2] = second_z_i;

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    pdmm_lane u_lane (
      .clk_i  (clk_i),
      .load_i (accept),
      .wrap_i (!vmode_q),
      .a_i    (first_c[g]),
      .b_i    (second_c[g]),
      .sq_o   (sq[g])
    );
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sq[0] + sq[1] + sq[2];
  end

  pdmm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .radicand_i (sum_q),
    .stat_o     (sqrt_stat),
    .root_o     (root)
  );

  assign root_dist  = DIST_W'(root);
  assign min_d      = (root_dist < min_q) ? root_dist : min_q;
  assign max_d      = (root_dist > max_q) ? root_dist : max_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign root_ready = ((state_q == S_ROOT) && sqrt_stat.done) || (state_q == S_HOLD);
  assign load_out   = root_ready && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      vmode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= '1;
      max_q       <= '0;
      dist_q      <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        vmode_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        dist_q      <= root_dist;
        min_q       <= min_d;
        max_q       <= max_d;
        out_min_q   <= min_d;
        out_max_q   <= max_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_LANE;
            cnt_q   <= '0;
          end
        end
        S_LANE: begin
          cnt_q <= cnt_q + LCNT_W'(1);
          if (cnt_q == LCNT_W'(LANE_LAT - 1)) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_stat.done) begin
            state_q <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign distance_o   = dist_q;
  assign min_so_far_o = out_min_q;
  assign max_so_far_o = out_max_q;

  `PDMM_ASSERT(a_out_order, out_valid_q |-> (out_min_q <= dist_q && dist_q <= out_max_q), "min max order")
  `PDMM_ASSERT(a_idle_sqrt, (state_q == S_IDLE) |-> !sqrt_stat.busy, "root unit busy while idle")
  `PDMM_ASSERT(a_done_root, sqrt_stat.done |-> (state_q == S_ROOT), "root done outside wait state")
  `PDMM_ASSERT(a_load_once, load_out |=> !root_ready, "finished root loaded twice")

endmodule

[bench/periodic_distance_with_min_max_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_distance_with_min_max_unit_tb
// checks each distance and the running min and max against a bit-exact
// model of the wrapped and unwrapped euclidean distance. a directed table
// covers the half-box wrap, the coordinate extremes and repeated distances.
// random phases then alternate position and velocity mode under bursty input
// (one phase sends without gaps) and a random output stall.
// ----------------------------------------------------------------------------

module periodic_distance_with_min_max_unit_tb;
  import pdmm_pkg::*;

  localparam logic MODE_POSITION = 1'b0;
  localparam logic MODE_VELOCITY = 1'b1;
  localparam int   SQ_BITS       = 70;
  localparam int   NUM_DIRECTED  = 19;
  localparam int   RANDOM_PHASES = 6;
  localparam int   PHASE_ITEMS   = 100;
  localparam int   SETTLE_CYCLES = 60;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef struct packed { coord_t fx, fy, fz, sx, sy, sz; } pair_t;
  typedef struct packed { logic vel; pair_t pair; logic known; dist_t expected; } dir_row_t;
  typedef struct packed { dist_t span, lo, hi; } dist_triple_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_we_i = 1'b0;
  logic   cfg_wdata_i = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  coord_t first_x_i = '0;
  coord_t first_y_i = '0;
  coord_t first_z_i = '0;
  coord_t second_x_i = '0;
  coord_t second_y_i = '0;
  coord_t second_z_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  dist_t  distance_o;
  dist_t  min_so_far_o;
  dist_t  max_so_far_o;

  dist_triple_t distance_fifo[$];
  logic  vel_mode = MODE_POSITION;
  dist_t shortest = '1;
  dist_t longest = '0;
  int    mismatches = 0;
  int    burst_left = 0;
  bit    eager_sender = 1'b0;
  int    stall_run = 0;

  // 4000_0000 and c000_0000 are half a box apart; 7fff_ffff vs 8000_0000 wraps to one
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_POSITION, '{32'sd3, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd5},
    '{MODE_POSITION, '{32'sd3, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd5},
    '{MODE_POSITION, '{32'h4000_0000, 32'sd0, 32'sd0, 32'hC000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd2147483648},
    '{MODE_POSITION, '{32'hC000_0000, 32'sd0, 32'sd0, 32'h4000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd2147483648},
    '{MODE_POSITION, '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
      32'hC000_0000, 32'hC000_0000, 32'hC000_0000}, 1'b0, 34'd0},
    '{MODE_POSITION, '{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd1},
    '{MODE_POSITION, '{32'h8000_0000, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'sd0},
      1'b1, 34'd1},
    '{MODE_POSITION, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1, 34'd1},
    '{MODE_POSITION, '{32'sd0, 32'sd0, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd2147483648},
    '{MODE_POSITION, '{32'sd1000, -32'sd2000, 32'sd300000, 32'sd0, 32'sd7, -32'sd9},
      1'b0, 34'd0},
    '{MODE_POSITION, '{-32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd1},
    '{MODE_VELOCITY, '{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd4294967295},
    '{MODE_VELOCITY, '{32'h8000_0000, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'sd0},
      1'b1, 34'd4294967295},
    '{MODE_VELOCITY, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, 34'd0},
    '{MODE_VELOCITY, '{32'h4000_0000, 32'sd0, 32'sd0, 32'hC000_0000, 32'sd0, 32'sd0},
      1'b1, 34'd2147483648},
    '{MODE_VELOCITY, '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd0,
      32'h8000_0000, 32'h7FFF_FFFF, 32'sd0}, 1'b0, 34'd0},
    '{MODE_VELOCITY, '{32'sd3, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd5},
    '{MODE_VELOCITY, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd0},
    '{MODE_VELOCITY, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 34'd0}
  };

  periodic_distance_with_min_max_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .first_z_i    (first_z_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .second_z_i   (second_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .distance_o   (distance_o),
    .min_so_far_o (min_so_far_o),
    .max_so_far_o (max_so_far_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // magnitude of one component difference, wrapped to the box in position mode
  function automatic logic [DIFF_W-1:0] component_span(coord_t a, coord_t b, logic vel);
    logic signed [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (vel == MODE_POSITION) d = {d[COORD_W-1], d[COORD_W-1:0]};
    if (d[DIFF_W-1]) d = -d;
    return d;
  endfunction

  function automatic dist_t pair_distance(pair_t p, logic vel);
    logic [SQ_BITS-1:0] acc;
    logic [SQ_BITS-1:0] m;
    logic [SQ_BITS-1:0] c;
    dist_t root;
    acc = '0;
    m = SQ_BITS'(component_span(p.fx, p.sx, vel));
    acc = acc + m * m;
    m = SQ_BITS'(component_span(p.fy, p.sy, vel));
    acc = acc + m * m;
    m = SQ_BITS'(component_span(p.fz, p.sz, vel));
    acc = acc + m * m;
    root = '0;
    for (int k = DIST_W - 1; k >= 0; k--) begin
      c = SQ_BITS'(dist_t'(root | (dist_t'(1) << k)));
      if (c * c <= acc) root = dist_t'(c);
    end
    return root;
  endfunction

  function automatic void random_component(output coord_t a, output coord_t b);
    logic [COORD_W-1:0] delta;
    a = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: b = $urandom;
      3, 4: begin
        delta = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) delta = -delta;
        b = a + delta;
      end
      5, 6: b = (a ^ 32'h8000_0000) + $urandom_range(0, 8) - 4;
      default: begin
        a = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(COORD_W-1){$urandom_range(0, 1) == 1}}};
        b = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(COORD_W-1){$urandom_range(0, 1) == 1}}};
      end
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    random_component(p.fx, p.sx);
    random_component(p.fy, p.sy);
    random_component(p.fz, p.sz);
    return p;
  endfunction

  task automatic send_pair(input pair_t p, input logic known, input dist_t known_dist);
    int gap;
    dist_t d;
    gap = 0;
    if (!eager_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(1, 60);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_x_i  <= p.fx;
    first_y_i  <= p.fy;
    first_z_i  <= p.fz;
    second_x_i <= p.sx;
    second_y_i <= p.sy;
    second_z_i <= p.sz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    d = pair_distance(p, vel_mode);
    if (d < shortest) shortest = d;
    if (d > longest) longest = d;
    distance_fifo.push_back(dist_triple_t'{known ? known_dist : d, shortest, longest});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (distance_fifo.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vel_mode = m;
  endtask

  initial begin : stimulus
    pair_t p;
    logic m;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].vel != vel_mode) begin
        drain();
        write_mode(directed_rows[i].vel);
      end
      send_pair(directed_rows[i].pair, directed_rows[i].known, directed_rows[i].expected);
    end
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      m = (ph % 2 == 0) ? MODE_POSITION : MODE_VELOCITY;
      write_mode(m);
      eager_sender = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = random_pair();
        send_pair(p, 1'b0, '0);
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS periodic_distance_with_min_max_unit");
    end else begin
      $display("FAIL periodic_distance_with_min_max_unit");
    end
    $finish;
  end

  // receiver: quiet stretches, long stalls and choppy toggling
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall_i <= 1'b0;
          stall_run   <= $urandom_range(100, 300);
        end
        1: begin
          out_stall_i <= 1'b1;
          stall_run   <= $urandom_range(1, 90);
        end
        default: begin
          out_stall_i <= $urandom_range(0, 1) == 1;
          stall_run   <= $urandom_range(0, 8);
        end
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(posedge clk_i) begin : check_results
    dist_triple_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (distance_fifo.size() == 0) begin
        $error("item with none pending: distance %0d", distance_o);
        mismatches++;
      end else begin
        want = distance_fifo.pop_front();
        if (distance_o !== want.span) begin
          $error("distance: expected %0d, got %0d", want.span, distance_o);
          mismatches++;
        end
        if (min_so_far_o !== want.lo) begin
          $error("min_so_far: expected %0d, got %0d", want.lo, min_so_far_o);
          mismatches++;
        end
        if (max_so_far_o !== want.hi) begin
          $error("max_so_far: expected %0d, got %0d", want.hi, max_so_far_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL periodic_distance_with_min_max_unit");
    $finish;
  end

endmodule
